// ----- rtl/mstb_pkg.sv -----
// shared constants and types for the soft timer bank
package mstb_pkg;

    localparam int NUM_TIMERS  = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ENTRY_W     = 2 * COUNT_WIDTH;

    // command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // result of the shared count unit for one slot
    typedef struct packed {
        logic                   expire;
        logic [COUNT_WIDTH-1:0] next_rem;
    } dec_res_t;

endpackage

// ----- rtl/mstb_ram.sv -----
// generic single write, single registered read ram
module mstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/mstb_dec_unit.sv -----
// shared compare and decrement unit for one slot count
module mstb_dec_unit (
    input  logic [mstb_pkg::COUNT_WIDTH-1:0] rem,
    input  logic [mstb_pkg::COUNT_WIDTH-1:0] reload,
    input  logic                             repeats,
    output mstb_pkg::dec_res_t               res
);
    import mstb_pkg::*;

    // count of one or less expires, otherwise count down
    always_comb
    begin
        res.expire = !(rem > COUNT_WIDTH'(1));
        if (!res.expire)
        begin
            res.next_rem = rem - COUNT_WIDTH'(1);
        end
        else if (repeats)
        begin
            res.next_rem = reload;
        end
        else
        begin
            res.next_rem = rem;
        end
    end

endmodule

// ----- rtl/multi_soft_timer_bank.sv -----
// A bank of countdown timers. Start and stop words are handled in the idle state and
// give no result. A tick word sweeps the slots in ascending order with one shared
// compare/decrement unit and one ram: an inactive slot is skipped in the read state,
// an active slot takes a ram read, then update and write back, and a closing flush
// state follows; the sweep stalls while the expiry output is held. Each expiry
// leaves as one word; one expiry is held back so that the last of the tick can be
// flagged. The next word is taken once the sweep has finished.
module multi_soft_timer_bank (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  logic [1:0]                       operation,
    input  logic [2:0]                       timer_index,
    input  logic                             repeat_mode,
    input  logic [31:0]                      period_length,
    output logic                             exp_valid,
    input  logic                             exp_ready,
    output logic [2:0]                       expired_index,
    output logic                             expired_repeats,
    output logic                             last_expiry
);
    import mstb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_FLUSH} state_t;

    state_t                  state_reg, state_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [NUM_TIMERS-1:0]   active_reg, active_next;
    logic [NUM_TIMERS-1:0]   repeat_reg, repeat_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]       pend_index_reg, pend_index_next;
    logic                    pend_repeats_reg, pend_repeats_next;
    logic                    out_valid_reg, out_valid_next;
    logic [2:0]              out_index_reg, out_index_next;
    logic                    out_repeats_reg, out_repeats_next;
    logic                    out_last_reg, out_last_next;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [COUNT_WIDTH-1:0]  len;
    logic [SLOT_W-1:0]       cmd_slot;
    logic                    cmd_in_range;
    logic                    last_slot;
    logic                    can_push;
    dec_res_t                dec_res;

    // count storage: reload in the upper half, remaining in the lower half
    mstb_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_TIMERS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    // shared count unit
    mstb_dec_unit u_dec (
        .rem    (ram_rdata[COUNT_WIDTH-1:0]),
        .reload (ram_rdata[ENTRY_W-1:COUNT_WIDTH]),
        .repeats(repeat_reg[slot_reg]),
        .res    (dec_res)
    );

    assign len          = COUNT_WIDTH'(period_length);
    assign cmd_slot     = SLOT_W'(timer_index);
    assign cmd_in_range = 32'(timer_index) < 32'(NUM_TIMERS);
    assign last_slot    = slot_reg == SLOT_W'(NUM_TIMERS - 1);
    assign can_push     = !out_valid_reg || exp_ready;

    assign cmd_ready       = state_reg == S_IDLE;
    assign exp_valid       = out_valid_reg;
    assign expired_index   = out_index_reg;
    assign expired_repeats = out_repeats_reg;
    assign last_expiry     = out_last_reg;

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        active_next       = active_reg;
        repeat_next       = repeat_reg;
        pend_valid_next   = pend_valid_reg;
        pend_index_next   = pend_index_reg;
        pend_repeats_next = pend_repeats_reg;
        out_valid_next    = out_valid_reg && !exp_ready;
        out_index_next    = out_index_reg;
        out_repeats_next  = out_repeats_reg;
        out_last_next     = out_last_reg;
        ram_we            = 1'b0;
        ram_waddr         = slot_reg;
        ram_wdata         = {ram_rdata[ENTRY_W-1:COUNT_WIDTH], dec_res.next_rem};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (operation)
                        OP_TICK:
                        begin
                            slot_next  = '0;
                            state_next = S_READ;
                        end
                        OP_START:
                        begin
                            if (cmd_in_range)
                            begin
                                ram_we                = 1'b1;
                                ram_waddr             = cmd_slot;
                                ram_wdata             = {len, len};
                                active_next[cmd_slot] = 1'b1;
                                repeat_next[cmd_slot] = repeat_mode;
                            end
                        end
                        OP_STOP:
                        begin
                            if (cmd_in_range)
                            begin
                                active_next[cmd_slot] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // inactive slots are skipped without a ram read
                if (active_reg[slot_reg])
                begin
                    state_next = S_EXEC;
                end
                else if (last_slot)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            S_EXEC:
            begin
                // hold while a pending expiry cannot move to the output
                if (!(dec_res.expire && pend_valid_reg && !can_push))
                begin
                    ram_we = 1'b1;
                    if (dec_res.expire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next   = 1'b1;
                            out_index_next   = 3'(pend_index_reg);
                            out_repeats_next = pend_repeats_reg;
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next   = 1'b1;
                        pend_index_next   = slot_reg;
                        pend_repeats_next = repeat_reg[slot_reg];
                        if (!repeat_reg[slot_reg])
                        begin
                            active_next[slot_reg] = 1'b0;
                        end
                    end
                    if (last_slot)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                // the held expiry is the last of this tick
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    out_valid_next   = 1'b1;
                    out_index_next   = 3'(pend_index_reg);
                    out_repeats_next = pend_repeats_reg;
                    out_last_next    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_reg       <= '0;
            active_reg     <= '0;
            repeat_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            active_reg     <= active_next;
            repeat_reg     <= repeat_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_index_reg   <= pend_index_next;
        pend_repeats_reg <= pend_repeats_next;
        out_index_reg    <= out_index_next;
        out_repeats_reg  <= out_repeats_next;
        out_last_reg     <= out_last_next;
    end

endmodule

// ----- rtl/mstb_checker.sv -----
// port level checks for the soft timer bank and their bind
module mstb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] operation,
    input logic       exp_valid,
    input logic       exp_ready,
    input logic [2:0] expired_index,
    input logic       expired_repeats,
    input logic       last_expiry
);
    import mstb_pkg::*;

    // a held expiry word does not change
    a_exp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid && !exp_ready |=> exp_valid && $stable(expired_index)
            && $stable(expired_repeats) && $stable(last_expiry))
        else $error("expiry word changed while stalled");

    // start, stop and unused words leave the bank ready again in the next cycle
    a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && operation != OP_TICK |=> cmd_ready)
        else $error("command word did not finish in one cycle");

    // a tick starts a sweep that blocks new words
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && operation == OP_TICK |=> !cmd_ready)
        else $error("tick did not start a sweep");

endmodule

bind multi_soft_timer_bank mstb_checker u_mstb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .operation      (operation),
    .exp_valid      (exp_valid),
    .exp_ready      (exp_ready),
    .expired_index  (expired_index),
    .expired_repeats(expired_repeats),
    .last_expiry    (last_expiry)
);
